### rtl/slkf_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slkf_pkg
// Shared types and constants for the serial line editor with kana folding.
// -----------------------------------------------------------------------------
package slkf_pkg;

   localparam int LINE_DEPTH_DEF = 64;
   localparam int CAP_REG_W      = 6;
   localparam int CAP_W          = CAP_REG_W + 1;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [CAP_REG_W-1:0] CAP_RESET = 6'd63;

   localparam logic [7:0] BYTE_BS       = 8'h08;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_TILDE    = 8'h7E;
   localparam logic [7:0] BYTE_DEL      = 8'h7F;
   localparam logic [7:0] BYTE_SJIS_LO  = 8'h81;
   localparam logic [7:0] BYTE_SJIS_HI  = 8'h9F;
   localparam logic [7:0] BYTE_UTF_LO   = 8'hE0;
   localparam logic [7:0] BYTE_UTF_HI   = 8'hEF;
   localparam logic [7:0] BYTE_KANA_LO  = 8'hA1;
   localparam logic [7:0] BYTE_KANA_MID = 8'hBF;
   localparam logic [7:0] BYTE_KANA_HI  = 8'hDF;
   localparam logic [7:0] BYTE_HW_BD    = 8'hBD;
   localparam logic [7:0] BYTE_HW_BE    = 8'hBE;
   localparam logic [7:0] BYTE_TRAIL_LO = 8'h80;
   localparam logic [7:0] KANA_SHIFT    = 8'h40;

   localparam logic [1:0] CH_ECHO = 2'd0;
   localparam logic [1:0] CH_LINE = 2'd1;
   localparam logic [1:0] CH_END  = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SECOND,
      PH_THIRD,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      CMD_ENTER,
      CMD_ERASE,
      CMD_CHAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ECHO,
      BK_NEWLINE,
      BK_DUMP,
      BK_MARK
   } back_state_type;

endpackage

### rtl/slkf_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slkf_front
// Byte decoder: tracks multi-byte sequences and turns bytes into edit commands.
// -----------------------------------------------------------------------------
module slkf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   output logic              in_ready,
   input  logic              cmd_ready,
   output logic              cmd_push,
   output slkf_pkg::cmd_type cmd
);

   slkf_pkg::phase_type phase_ff, phase_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] second_ff, second_in;
   logic       take;
   logic       act;
   logic       is_print;
   logic       is_kana;

   assign in_ready = cmd_ready;
   assign take     = in_valid && cmd_ready;
   assign is_print = (in_byte >= slkf_pkg::BYTE_SPACE) && (in_byte <= slkf_pkg::BYTE_TILDE);
   assign is_kana  = (in_byte >= slkf_pkg::BYTE_KANA_LO) && (in_byte <= slkf_pkg::BYTE_KANA_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= slkf_pkg::PH_IDLE;
         lead_ff   <= '0;
         second_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      act       = 1'b0;
      cmd.kind  = slkf_pkg::CMD_CHAR;
      cmd.data  = in_byte;
      unique case (phase_ff)
         slkf_pkg::PH_SECOND: begin
            second_in = in_byte;
            phase_in  = slkf_pkg::PH_THIRD;
         end
         slkf_pkg::PH_THIRD: begin
            phase_in = slkf_pkg::PH_IDLE;
            if (lead_ff == slkf_pkg::BYTE_UTF_HI) begin
               if (second_ff == slkf_pkg::BYTE_HW_BD && in_byte >= slkf_pkg::BYTE_KANA_LO
                   && in_byte <= slkf_pkg::BYTE_KANA_MID) begin
                  act = 1'b1;
               end else if (second_ff == slkf_pkg::BYTE_HW_BE
                            && in_byte >= slkf_pkg::BYTE_TRAIL_LO
                            && in_byte <= slkf_pkg::BYTE_SJIS_HI) begin
                  act      = 1'b1;
                  cmd.data = in_byte + slkf_pkg::KANA_SHIFT;
               end
            end
         end
         slkf_pkg::PH_SKIP: begin
            phase_in = slkf_pkg::PH_IDLE;
         end
         default: begin
            priority if (in_byte >= slkf_pkg::BYTE_UTF_LO && in_byte <= slkf_pkg::BYTE_UTF_HI) begin
               lead_in  = in_byte;
               phase_in = slkf_pkg::PH_SECOND;
            end else if (in_byte >= slkf_pkg::BYTE_SJIS_LO
                         && in_byte <= slkf_pkg::BYTE_SJIS_HI) begin
               phase_in = slkf_pkg::PH_SKIP;
            end else if (in_byte == slkf_pkg::BYTE_CR || in_byte == slkf_pkg::BYTE_LF) begin
               act      = 1'b1;
               cmd.kind = slkf_pkg::CMD_ENTER;
            end else if (in_byte == slkf_pkg::BYTE_BS || in_byte == slkf_pkg::BYTE_DEL) begin
               act      = 1'b1;
               cmd.kind = slkf_pkg::CMD_ERASE;
            end else if (is_print || is_kana) begin
               act = 1'b1;
            end else begin
               act = 1'b0;
            end
         end
      endcase
      if (!take) begin
         phase_in  = phase_ff;
         lead_in   = lead_ff;
         second_in = second_ff;
      end
   end

   assign cmd_push = take && act;

endmodule

### rtl/slkf_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slkf_queue
// Short command queue between the byte decoder and the line engine.
// -----------------------------------------------------------------------------
module slkf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slkf_pkg::cmd_type push_cmd,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output slkf_pkg::cmd_type head
);

   localparam int PTR_W = $clog2(slkf_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(slkf_pkg::QUEUE_DEPTH + 1);

   slkf_pkg::cmd_type slot_ff [slkf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign not_full  = (count_ff != CNT_W'(slkf_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(slkf_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(slkf_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### rtl/slkf_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slkf_back
// Line engine: stores characters, erases, echoes and dumps the line on enter.
// -----------------------------------------------------------------------------
module slkf_back #(
   parameter int LINE_DEPTH = slkf_pkg::LINE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [slkf_pkg::CAP_REG_W-1:0] capacity,
   input  logic                           cmd_valid,
   input  slkf_pkg::cmd_type              cmd,
   output logic                           cmd_pop,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [1:0]                     out_channel,
   output logic [7:0]                     out_byte,
   output logic                           out_last
);

   localparam int IDX_W = $clog2(LINE_DEPTH);

   slkf_pkg::back_state_type state_ff, state_in;
   logic [7:0]       mem [LINE_DEPTH];
   logic [7:0]       rd_ff;
   logic [IDX_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       echo_ff [3];
   logic [7:0]       echo_in [3];
   logic [1:0]       pos_ff, pos_in;
   logic [1:0]       end_ff, end_in;
   logic             valid_ff, valid_in;
   logic [1:0]       chan_ff, chan_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             emit;
   logic             out_free;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [slkf_pkg::CAP_W-1:0] cap_lim;
   logic             room;

   assign out_free    = !valid_ff || out_ready;
   assign out_valid   = valid_ff;
   assign out_channel = chan_ff;
   assign out_byte    = byte_ff;
   assign out_last    = last_ff;

   assign cap_lim = ({1'b0, capacity} > slkf_pkg::CAP_W'(LINE_DEPTH))
                    ? slkf_pkg::CAP_W'(LINE_DEPTH) : {1'b0, capacity};
   assign room    = (slkf_pkg::CAP_W'(len_ff) + slkf_pkg::CAP_W'(1)) < cap_lim;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[len_ff] <= cmd.data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slkf_pkg::BK_IDLE;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
      idx_ff     <= idx_in;
      echo_ff[0] <= echo_in[0];
      echo_ff[1] <= echo_in[1];
      echo_ff[2] <= echo_in[2];
      pos_ff     <= pos_in;
      end_ff     <= end_in;
      chan_ff    <= chan_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      echo_in[0] = echo_ff[0];
      echo_in[1] = echo_ff[1];
      echo_in[2] = echo_ff[2];
      pos_in     = pos_ff;
      end_in     = end_ff;
      chan_in    = chan_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      emit       = 1'b0;
      cmd_pop    = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff + IDX_W'(1);
      unique case (state_ff)
         slkf_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               pos_in  = 2'd0;
               unique case (cmd.kind)
                  slkf_pkg::CMD_ENTER: begin
                     state_in = slkf_pkg::BK_NEWLINE;
                  end
                  slkf_pkg::CMD_ERASE: begin
                     if (len_ff != '0) begin
                        len_in     = len_ff - IDX_W'(1);
                        echo_in[0] = slkf_pkg::BYTE_BS;
                        echo_in[1] = slkf_pkg::BYTE_SPACE;
                        echo_in[2] = slkf_pkg::BYTE_BS;
                        end_in     = 2'd2;
                        state_in   = slkf_pkg::BK_ECHO;
                     end
                  end
                  default: begin
                     if (room) begin
                        wr_en    = 1'b1;
                        len_in   = len_ff + IDX_W'(1);
                        state_in = slkf_pkg::BK_ECHO;
                        if (cmd.data >= slkf_pkg::BYTE_KANA_LO) begin
                           echo_in[0] = slkf_pkg::BYTE_UTF_HI;
                           end_in     = 2'd2;
                           if (cmd.data <= slkf_pkg::BYTE_KANA_MID) begin
                              echo_in[1] = slkf_pkg::BYTE_HW_BD;
                              echo_in[2] = cmd.data;
                           end else begin
                              echo_in[1] = slkf_pkg::BYTE_HW_BE;
                              echo_in[2] = cmd.data - slkf_pkg::KANA_SHIFT;
                           end
                        end else begin
                           echo_in[0] = cmd.data;
                           end_in     = 2'd0;
                        end
                     end
                  end
               endcase
            end
         end
         slkf_pkg::BK_ECHO: begin
            if (out_free) begin
               emit    = 1'b1;
               chan_in = slkf_pkg::CH_ECHO;
               byte_in = echo_ff[pos_ff];
               last_in = (pos_ff == end_ff);
               pos_in  = pos_ff + 2'd1;
               if (pos_ff == end_ff) begin
                  state_in = slkf_pkg::BK_IDLE;
               end
            end
         end
         slkf_pkg::BK_NEWLINE: begin
            if (out_free) begin
               emit     = 1'b1;
               chan_in  = slkf_pkg::CH_ECHO;
               byte_in  = slkf_pkg::BYTE_LF;
               last_in  = 1'b0;
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = (len_ff == '0) ? slkf_pkg::BK_MARK : slkf_pkg::BK_DUMP;
            end
         end
         slkf_pkg::BK_DUMP: begin
            if (out_free) begin
               emit    = 1'b1;
               chan_in = slkf_pkg::CH_LINE;
               byte_in = rd_ff;
               last_in = 1'b0;
               idx_in  = idx_ff + IDX_W'(1);
               rd_en   = 1'b1;
               if (idx_ff == len_ff - IDX_W'(1)) begin
                  state_in = slkf_pkg::BK_MARK;
               end
            end
         end
         slkf_pkg::BK_MARK: begin
            if (out_free) begin
               emit     = 1'b1;
               chan_in  = slkf_pkg::CH_END;
               byte_in  = '0;
               last_in  = 1'b1;
               len_in   = '0;
               state_in = slkf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = slkf_pkg::BK_IDLE;
         end
      endcase
      valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

endmodule

### rtl/serial_line_editor_kana_fold_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// serial_line_editor_kana_fold_core
// Terminal line editor with UTF-8 half-width kana folding.
// -----------------------------------------------------------------------------
// Bytes enter at one per cycle into a decoder that tracks UTF-8 and Shift-JIS
// sequences and queues edit commands in a two-entry queue; the input stalls
// only while that queue is full. The line engine behind it takes one command
// at a time and emits one result per cycle when the output register is free:
// a printable byte gives one echo byte, a kana or an erase three, an enter a
// line feed, the stored line read from the line memory one character a cycle
// and a line-end marker. Bytes that only advance decoding, or that are
// dropped, give no result. The csr_wdata capacity limits stored characters
// to min(capacity, LINE_DEPTH) - 1; write it only while the block is idle.
// -----------------------------------------------------------------------------
module serial_line_editor_kana_fold_core #(
   parameter int LINE_DEPTH = slkf_pkg::LINE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic [1:0]                     rsp_tuser,   // [1:0] channel
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [slkf_pkg::CAP_REG_W-1:0] csr_wdata
);

   logic [slkf_pkg::CAP_REG_W-1:0] capacity_ff;
   slkf_pkg::cmd_type push_cmd, head_cmd;
   logic push, not_full, pop, not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= slkf_pkg::CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   slkf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_ready  (req_tready),
      .cmd_ready (not_full),
      .cmd_push  (push),
      .cmd       (push_cmd)
   );

   slkf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head_cmd)
   );

   slkf_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .cmd_valid   (not_empty),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_channel (rsp_tuser),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

### bench/serial_line_editor_kana_fold_core_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// serial_line_editor_kana_fold_core_tb
// Self-checking bench for the terminal line editor with kana folding.
// -----------------------------------------------------------------------------
// Feeds received bytes on the request stream and predicts every echo byte,
// line character and line-end marker in a small scoreboard that tracks the
// UTF-8 and Shift-JIS decoding, the line contents and the capacity limit.
// A short directed burst hits field extremes, kana folding, dropped
// sequences, trail bytes and erase on an empty line. Random phases follow
// with mostly well-formed text, several capacity settings written while
// the block is idle, and, in most of them, random stalls on both streams.
// -----------------------------------------------------------------------------

typedef struct packed {
   logic [1:0] channel;
   logic [7:0] data;
   logic       last;
} line_result_type;

class line_scoreboard;
   logic [5:0]          capacity;
   slkf_pkg::phase_type phase;
   logic [7:0]          lead_byte;
   logic [7:0]          second_byte;
   logic [7:0]          line_chars [slkf_pkg::LINE_DEPTH_DEF];
   int unsigned         line_len;
   line_result_type     expected_q [$];
   int                  errors;
   int                  bytes_in;
   int                  results_out;

   function new();
      capacity    = slkf_pkg::CAP_RESET;
      phase       = slkf_pkg::PH_IDLE;
      lead_byte   = 8'h00;
      second_byte = 8'h00;
      line_len    = 0;
      errors      = 0;
      bytes_in    = 0;
      results_out = 0;
   endfunction

   function void set_capacity(logic [5:0] value);
      capacity = value;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void emit(logic [1:0] channel, logic [7:0] data);
      line_result_type r;
      r.channel = channel;
      r.data    = data;
      r.last    = 1'b0;
      expected_q.push_back(r);
   endfunction

   function void edit_line(logic [7:0] c);
      int unsigned i;
      if (c == slkf_pkg::BYTE_CR || c == slkf_pkg::BYTE_LF) begin
         emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_LF);
         for (i = 0; i < line_len; i++)
            emit(slkf_pkg::CH_LINE, line_chars[i]);
         emit(slkf_pkg::CH_END, 8'h00);
         line_len = 0;
      end else if (c == slkf_pkg::BYTE_BS || c == slkf_pkg::BYTE_DEL) begin
         if (line_len > 0) begin
            line_len--;
            emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_BS);
            emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_SPACE);
            emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_BS);
         end
      end else if (((c >= slkf_pkg::BYTE_SPACE && c <= slkf_pkg::BYTE_TILDE) ||
                    (c >= slkf_pkg::BYTE_KANA_LO && c <= slkf_pkg::BYTE_KANA_HI)) &&
                   (line_len + 1 < int'(capacity))) begin
         line_chars[line_len] = c;
         line_len++;
         if (c >= slkf_pkg::BYTE_KANA_LO) begin
            emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_UTF_HI);
            if (c <= slkf_pkg::BYTE_KANA_MID) begin
               emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_HW_BD);
               emit(slkf_pkg::CH_ECHO, c);
            end else begin
               emit(slkf_pkg::CH_ECHO, slkf_pkg::BYTE_HW_BE);
               emit(slkf_pkg::CH_ECHO, c - slkf_pkg::KANA_SHIFT);
            end
         end else begin
            emit(slkf_pkg::CH_ECHO, c);
         end
      end
   endfunction

   function void note_byte(logic [7:0] b);
      int before_n;
      before_n = expected_q.size();
      bytes_in++;
      case (phase)
         slkf_pkg::PH_SECOND: begin
            second_byte = b;
            phase = slkf_pkg::PH_THIRD;
         end
         slkf_pkg::PH_THIRD: begin
            phase = slkf_pkg::PH_IDLE;
            if (lead_byte == slkf_pkg::BYTE_UTF_HI) begin
               if (second_byte == slkf_pkg::BYTE_HW_BD && b >= slkf_pkg::BYTE_KANA_LO
                   && b <= slkf_pkg::BYTE_KANA_MID)
                  edit_line(b);
               else if (second_byte == slkf_pkg::BYTE_HW_BE && b >= slkf_pkg::BYTE_TRAIL_LO
                        && b <= slkf_pkg::BYTE_SJIS_HI)
                  edit_line(b + slkf_pkg::KANA_SHIFT);
            end
         end
         slkf_pkg::PH_SKIP: phase = slkf_pkg::PH_IDLE;
         default: begin
            if (b >= slkf_pkg::BYTE_UTF_LO && b <= slkf_pkg::BYTE_UTF_HI) begin
               lead_byte = b;
               phase = slkf_pkg::PH_SECOND;
            end else if (b >= slkf_pkg::BYTE_SJIS_LO && b <= slkf_pkg::BYTE_SJIS_HI) begin
               phase = slkf_pkg::PH_SKIP;
            end else begin
               edit_line(b);
            end
         end
      endcase
      if (expected_q.size() > before_n)
         expected_q[expected_q.size() - 1].last = 1'b1;
   endfunction

   task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
   endtask

   task check_result(logic [1:0] channel, logic [7:0] data, logic last);
      line_result_type got;
      line_result_type want;
      got.channel = channel;
      got.data    = data;
      got.last    = last;
      results_out++;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected item ch=%0d byte=%02h last=%0b",
                          channel, data, last));
      end else begin
         want = expected_q.pop_front();
         if (got !== want)
            report($sformatf({"item %0d: got ch=%0d byte=%02h last=%0b,",
                              " want ch=%0d byte=%02h last=%0b"},
                             results_out, got.channel, got.data, got.last,
                             want.channel, want.data, want.last));
      end
   endtask
endclass

module serial_line_editor_kana_fold_core_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 70;
   localparam int PHASE_ITEMS   = 22;

   localparam logic [7:0] DIRECTED [27] = '{
      8'h08, 8'h20, 8'h7E, 8'h1F, 8'h00, 8'hFF,
      8'hEF, 8'hBD, 8'hA1,
      8'hEF, 8'hBE, 8'h9F,
      8'hEF, 8'hBD, 8'hA0,
      8'hE0, 8'h0D, 8'h0A,
      8'h81, 8'h0D,
      8'hDF, 8'h7F, 8'h0D, 8'h7F, 8'h80, 8'h41, 8'h0A
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic [slkf_pkg::CAP_REG_W-1:0] csr_wdata = slkf_pkg::CAP_RESET;

   line_scoreboard sb = new();
   logic [7:0]     stim_q [$];
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             cycles = 0;
   int             cap_writes = 0;

   serial_line_editor_kana_fold_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [slkf_pkg::CAP_REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_capacity(value);
      cap_writes++;
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 34; recv_idle_pct = 68; end
         1: begin send_idle_pct = 68; recv_idle_pct = 34; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   // Mostly well-formed text with random content; the rest is broken
   // sequences and noise.
   task automatic build_random_items(input int target, input int line_end_pct);
      int pick;
      stim_q.delete();
      while (stim_q.size() < target) begin
         pick = $urandom_range(99);
         if (pick < line_end_pct) begin
            stim_q.push_back($urandom_range(1) ? slkf_pkg::BYTE_CR : slkf_pkg::BYTE_LF);
         end else if (pick < 50) begin
            stim_q.push_back(8'($urandom_range(32, 126)));
         end else if (pick < 63) begin
            stim_q.push_back(slkf_pkg::BYTE_UTF_HI);
            if ($urandom_range(1)) begin
               stim_q.push_back(slkf_pkg::BYTE_HW_BD);
               stim_q.push_back(8'($urandom_range(8'hA1, 8'hBF)));
            end else begin
               stim_q.push_back(slkf_pkg::BYTE_HW_BE);
               stim_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
            end
         end else if (pick < 68) begin
            stim_q.push_back(8'($urandom_range(8'hA1, 8'hDF)));
         end else if (pick < 74) begin
            stim_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            stim_q.push_back(8'($urandom_range(255)));
            stim_q.push_back(8'($urandom_range(255)));
         end else if (pick < 79) begin
            stim_q.push_back(8'($urandom_range(8'h81, 8'h9F)));
            stim_q.push_back(8'($urandom_range(255)));
         end else if (pick < 88) begin
            stim_q.push_back($urandom_range(1) ? slkf_pkg::BYTE_BS : slkf_pkg::BYTE_DEL);
         end else begin
            stim_q.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      logic [slkf_pkg::CAP_REG_W-1:0] cap_list [5];
      logic [slkf_pkg::CAP_REG_W-1:0] cap;
      cap_list = '{6'd2, 6'd63, 6'd0, 6'd9, 6'd1};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle_mode(0);
      foreach (DIRECTED[i])
         send_byte(DIRECTED[i]);
      drain_results();

      for (int p = 0; p < 6; p++) begin
         cap = (p < 5) ? cap_list[p] : slkf_pkg::CAP_REG_W'($urandom_range(3, 62));
         write_capacity(cap);
         set_idle_mode(p / 2);
         build_random_items(PHASE_ITEMS, (cap == 6'd63) ? 2 : 8);
         foreach (stim_q[i])
            send_byte(stim_q[i]);
         drain_results();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.pending()));

      $display("tb: %0d input items, %0d result items checked", sb.bytes_in, sb.results_out);
      $display("tb: %0d capacity writes, stalls on both streams, %0d mismatches",
               cap_writes, sb.errors);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
